// ===== rtl/core/pot_pkg.sv =====
`default_nettype none
package pot_pkg;

  // coordinate format
  localparam int COORD_BITS = 16;
  localparam int AXES       = 3;
  localparam int PACK_W     = 48;
  localparam int RAD_W      = 16;

  // datapath widths
  localparam int MAG_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 2;

  // shape kinds
  localparam logic [1:0] KIND_SPHERE  = 2'd0;
  localparam logic [1:0] KIND_AABB    = 2'd1;
  localparam logic [1:0] KIND_OBB     = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_TESTED      = 2'd0;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
  localparam logic [1:0] STATUS_INVALID     = 2'd2;

  // pair test selected by the front
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SS   = 2'd1;
  localparam logic [1:0] MODE_SB   = 2'd2;
  localparam logic [1:0] MODE_BB   = 2'd3;

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef struct packed {
    logic [1:0]        type_a;
    logic [1:0]        type_b;
    logic [PACK_W-1:0] pos_a;
    logic [PACK_W-1:0] pos_b;
    logic [PACK_W-1:0] min_a;
    logic [PACK_W-1:0] max_a;
    logic [RAD_W-1:0]  radius_a;
    logic [PACK_W-1:0] min_b;
    logic [PACK_W-1:0] max_b;
    logic [RAD_W-1:0]  radius_b;
  } item_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] status;
  } result_t;

  // classified pair: shape 0 is the sphere for a sphere-box pair
  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        mode;
    logic [PACK_W-1:0] p0;
    logic [RAD_W-1:0]  r0;
    logic [PACK_W-1:0] mn0;
    logic [PACK_W-1:0] mx0;
    logic [PACK_W-1:0] p1;
    logic [RAD_W-1:0]  r1;
    logic [PACK_W-1:0] mn1;
    logic [PACK_W-1:0] mx1;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/pot_front.sv =====
`default_nettype none
module pot_front (
  input  pot_pkg::item_t  item,
  output pot_pkg::entry_t entry
);

  always_comb begin
    entry.status = pot_pkg::STATUS_TESTED;
    entry.mode   = pot_pkg::MODE_NONE;
    entry.p0     = item.pos_a;
    entry.r0     = item.radius_a;
    entry.mn0    = item.min_a;
    entry.mx0    = item.max_a;
    entry.p1     = item.pos_b;
    entry.r1     = item.radius_b;
    entry.mn1    = item.min_b;
    entry.mx1    = item.max_b;
    priority if (item.type_a == pot_pkg::KIND_INVALID ||
                 item.type_b == pot_pkg::KIND_INVALID) begin
      entry.status = pot_pkg::STATUS_INVALID;
    end else if (item.type_a == pot_pkg::KIND_OBB ||
                 item.type_b == pot_pkg::KIND_OBB) begin
      entry.status = pot_pkg::STATUS_UNSUPPORTED;
    end else if (item.type_a == pot_pkg::KIND_SPHERE &&
                 item.type_b == pot_pkg::KIND_SPHERE) begin
      entry.mode = pot_pkg::MODE_SS;
    end else if (item.type_a == pot_pkg::KIND_SPHERE) begin
      entry.mode = pot_pkg::MODE_SB;
    end else if (item.type_b == pot_pkg::KIND_SPHERE) begin
      // box first, sphere second: swap so the sphere is shape 0
      entry.mode = pot_pkg::MODE_SB;
      entry.p0   = item.pos_b;
      entry.r0   = item.radius_b;
      entry.mn0  = item.min_b;
      entry.mx0  = item.max_b;
      entry.p1   = item.pos_a;
      entry.r1   = item.radius_a;
      entry.mn1  = item.min_a;
      entry.mx1  = item.max_a;
    end else begin
      entry.mode = pot_pkg::MODE_BB;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pot_queue.sv =====
`default_nettype none
module pot_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  pot_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pot_pkg::entry_t pop_data
);

  pot_pkg::entry_t                    mem [pot_pkg::QUEUE_DEPTH];
  logic [pot_pkg::QUEUE_PTR_W-1:0]    wptr;
  logic [pot_pkg::QUEUE_PTR_W-1:0]    rptr;
  logic [pot_pkg::QUEUE_CNT_W-1:0]    count;
  logic                               do_push;
  logic                               do_pop;

  assign push_ready = (count != pot_pkg::QUEUE_CNT_W'(pot_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pot_back.sv =====
`default_nettype none
module pot_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             entry_valid,
  output logic             entry_ready,
  input  pot_pkg::entry_t  entry,
  output logic             result_valid,
  input  logic             result_ready,
  output pot_pkg::result_t result
);

  localparam int CB = pot_pkg::COORD_BITS;

  function automatic logic signed [CB:0] lane(input logic [pot_pkg::PACK_W-1:0] v,
                                               input int k);
    logic signed [CB-1:0] l;
    l = $signed(v[k*CB +: CB]);
    return (CB+1)'(l);
  endfunction

  // magnitude of a difference; its value always fits CB+1 bits
  function automatic logic [pot_pkg::MAG_W-1:0] mag(input logic signed [CB+1:0] d);
    logic [CB+1:0] m;
    m = d[CB+1] ? $unsigned(-d) : $unsigned(d);
    return m[pot_pkg::MAG_W-1:0];
  endfunction

  // stage 1: per-axis deltas and box interval checks
  logic                          s1_valid;
  logic [pot_pkg::MAG_W-1:0]     s1_mag [pot_pkg::AXES];
  logic [pot_pkg::MAG_W-1:0]     s1_rad;
  logic                          s1_ov;
  logic [1:0]                    s1_mode;
  logic [1:0]                    s1_status;

  // stage 2: squares
  logic                          s2_valid;
  logic [pot_pkg::SQ_W-1:0]      s2_sq [pot_pkg::AXES];
  logic [pot_pkg::SQ_W-1:0]      s2_rsq;
  logic                          s2_ov;
  logic [1:0]                    s2_mode;
  logic [1:0]                    s2_status;

  logic                          out_adv;
  logic                          s2_adv;
  logic                          s1_adv;

  logic [pot_pkg::MAG_W-1:0]     mag_next [pot_pkg::AXES];
  logic [pot_pkg::MAG_W-1:0]     rad_next;
  logic                          ov_next;
  logic [pot_pkg::SUM_W-1:0]     d2;
  logic                          hit_next;

  assign out_adv     = !result_valid || result_ready;
  assign s2_adv      = !s2_valid || out_adv;
  assign s1_adv      = !s1_valid || s2_adv;
  assign entry_ready = s1_adv;

  always_comb begin
    logic signed [CB:0]   c;
    logic signed [CB:0]   b;
    logic signed [CB:0]   lo;
    logic signed [CB:0]   hi;
    logic signed [CB:0]   a_lo;
    logic signed [CB:0]   a_hi;
    logic signed [CB:0]   q;
    logic signed [CB+1:0] d;
    ov_next = 1'b1;
    for (int k = 0; k < pot_pkg::AXES; k++) begin
      c    = lane(entry.p0, k);
      b    = lane(entry.p1, k);
      lo   = lane(entry.mn1, k) + b;
      hi   = lane(entry.mx1, k) + b;
      a_lo = lane(entry.mn0, k) + c;
      a_hi = lane(entry.mx0, k) + c;
      // clamp to min first, then max, so an inverted box ends on its max
      q = c;
      if (q < lo) q = lo;
      if (q > hi) q = hi;
      if (entry.mode == pot_pkg::MODE_SS) begin
        d = (CB+2)'(c) - (CB+2)'(b);
      end else begin
        d = (CB+2)'(q) - (CB+2)'(c);
      end
      mag_next[k] = mag(d);
      if (a_lo > hi || a_hi < lo) begin
        ov_next = 1'b0;
      end
    end
    if (entry.mode == pot_pkg::MODE_SS) begin
      rad_next = pot_pkg::MAG_W'(entry.r0) + pot_pkg::MAG_W'(entry.r1);
    end else begin
      rad_next = pot_pkg::MAG_W'(entry.r0);
    end
  end

  always_comb begin
    d2 = pot_pkg::SUM_W'(s2_sq[0]) + pot_pkg::SUM_W'(s2_sq[1])
       + pot_pkg::SUM_W'(s2_sq[2]);
    if (s2_status != pot_pkg::STATUS_TESTED) begin
      hit_next = 1'b0;
    end else if (s2_mode == pot_pkg::MODE_BB) begin
      hit_next = s2_ov;
    end else begin
      hit_next = (d2 <= pot_pkg::SUM_W'(s2_rsq));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= entry_valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
      if (out_adv) begin
        result_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_mag    <= mag_next;
      s1_rad    <= rad_next;
      s1_ov     <= ov_next;
      s1_mode   <= entry.mode;
      s1_status <= entry.status;
    end
    if (s2_adv) begin
      for (int k = 0; k < pot_pkg::AXES; k++) begin
        s2_sq[k] <= pot_pkg::SQ_W'(s1_mag[k]) * pot_pkg::SQ_W'(s1_mag[k]);
      end
      s2_rsq    <= pot_pkg::SQ_W'(s1_rad) * pot_pkg::SQ_W'(s1_rad);
      s2_ov     <= s1_ov;
      s2_mode   <= s1_mode;
      s2_status <= s1_status;
    end
    if (out_adv) begin
      result.hit    <= hit_next;
      result.status <= s2_status;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/primitive_overlap_test.sv =====
// Sphere / axis-aligned box overlap test. Each transaction on item carries two
// shapes (sphere, axis box, oriented box or invalid kind) with signed Q8.8
// positions and box corners and unsigned Q8.8 radii; each returns exactly one
// transaction on result with hit and status. The block accepts one pair per
// clock while item_ready is high: the front classifies a pair in the cycle it
// is taken and writes it into a four-entry queue, and the back runs a
// three-stage pipeline (deltas and clamping, squaring, sum and compare into
// the output register). A result passes through the queue and then the
// pipeline stages in order; the queue and the pipeline stages stall on their
// own, so item_ready only drops when the queue is full.
`default_nettype none
module primitive_overlap_test (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pot_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output pot_pkg::result_t result
);

  // classified pair from the front, and the queue head for the back
  pot_pkg::entry_t front_entry;
  pot_pkg::entry_t head_entry;
  logic            head_valid;
  logic            head_ready;

  // front: kind checks, pair mode and sphere-first ordering
  pot_front u_front (
    .item  (item),
    .entry (front_entry)
  );

  // queue lets the front keep taking pairs while the output stalls
  pot_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (item_valid),
    .push_ready (item_ready),
    .push_data  (front_entry),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head_entry)
  );

  // back: distance and interval arithmetic, result register
  pot_back u_back (
    .clk          (clk),
    .rst          (rst),
    .entry_valid  (head_valid),
    .entry_ready  (head_ready),
    .entry        (head_entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
